>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bdil_pkg.sv
`default_nettype none

package bdil_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // counter and coordinate widths follow the maximum image size
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 11;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(240);
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // 3x3 window: three columns of three bits, oldest column lowest;
    // within a column bit 0 is row y-2, bit 1 row y-1, bit 2 row y
    localparam int WIN_W = 9;
    localparam logic [WIN_W-1:0] WIN_ALL         = 9'h1FF;
    localparam logic [WIN_W-1:0] WIN_RIGHT_CLIP  = 9'h1F8;
    localparam logic [WIN_W-1:0] WIN_BOTTOM_CLIP = 9'h1B6;
    localparam logic [WIN_W-1:0] WIN_CORNER_CLIP = 9'h1B0;

    // result slots of one input item, in emission order
    localparam int RES_N     = 4;
    localparam int RES_INNER = 0;  // (y-1, x-1)
    localparam int RES_REDGE = 1;  // (y-1, W-1)
    localparam int RES_BOT   = 2;  // (H-1, x-1)
    localparam int RES_CORN  = 3;  // (H-1, W-1), frame end

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

endpackage

`default_nettype wire

>>> hdl/binary_dilation_3x3_unit.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata[0] mask_bit
// m_        out        m_tvalid/m_tready  m_tdata row/col/dilated, m_tlast, m_tuser
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One input item per cycle: a mask pixel is taken while the result buffer is
// empty or its last result leaves in the same cycle. Row 0 and column 0 give
// no results; other interior pixels give one (two at row end). The last row
// gives two per item and four at row end; extra results drain one per cycle
// from the result buffer while m_tready is high and hold off s_tready meanwhile.
// Line store read data is registered, prefetched from the next column address.
// Reset (aresetn low, synchronous) clears counters, window, result buffer and
// sets the size registers to 320 x 240; the line store is not cleared.

`include "assert_macros.svh"

module binary_dilation_3x3_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bdil_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] mask_bit
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bdil_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [9:0] out_row,
                                                             // [19:10] out_col,
                                                             // [20] dilated_bit
    output logic                                  m_tlast,   // last_of_item
    output logic                                  m_tuser,   // [0] frame_end
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [bdil_pkg::SIZE_W-1:0]      cfg_data
);
    import bdil_pkg::*;

    // configuration
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;

    // frame position and window
    logic [COL_W-1:0]  col_count_reg, col_next;
    logic [ROW_W-1:0]  row_count_reg, row_next;
    logic [WIN_W-1:0]  window_reg, window_next;

    // line store: bit 1 row y-2, bit 0 row y-1
    logic [1:0]        line_mem [MAX_WIDTH];
    logic [1:0]        ls_rd_reg;
    logic [COL_W-1:0]  rd_addr;
    logic [1:0]        ls;

    // result buffer for one item
    logic [RES_N-1:0]  pend_reg, pend_next, pend_new;
    logic [ROW_W-1:0]  res_row_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic [WIN_W-1:0]  res_win_reg;

    logic              in_acc, out_acc;
    logic              mask_bit;
    logic              row_end, last_row;
    logic              has_up, has_left;

    logic [ROW_W-1:0]  sel_row;
    logic [COL_W-1:0]  sel_col;
    logic [WIN_W-1:0]  sel_mask;
    logic              sel_fend;
    logic [RES_N-1:0]  pend_rest;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sizes outside the supported range are clamped
    always_comb begin
        if (width_reg < SIZE_MIN)        w_eff = SIZE_MIN;
        else if (width_reg > WIDTH_MAX)  w_eff = WIDTH_MAX;
        else                             w_eff = width_reg;
        if (height_reg < SIZE_MIN)       h_eff = SIZE_MIN;
        else if (height_reg > HEIGHT_MAX) h_eff = HEIGHT_MAX;
        else                             h_eff = height_reg;
    end

    assign mask_bit = s_tdata[0];
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    // take a new item while the buffer is empty or empties this cycle
    assign pend_rest = pend_reg & (pend_reg - RES_N'(1));
    assign s_tready  = (pend_reg == '0) || ((pend_rest == '0) && m_tready);

    assign row_end  = {1'b0, col_count_reg} >= (w_eff - SIZE_W'(1));
    assign last_row = {1'b0, row_count_reg} >= (h_eff - SIZE_W'(1));
    assign has_up   = row_count_reg != '0;
    assign has_left = col_count_reg != '0;

    // rows above the top border read as zero
    assign ls = has_up ? ls_rd_reg : 2'b00;

    always_comb begin
        logic [WIN_W-1:0] win_base;
        win_base    = has_left ? window_reg : '0;
        window_next = (win_base >> 3) | {mask_bit, ls[0], ls[1], 6'b0};

        pend_new            = '0;
        pend_new[RES_INNER] = has_up && has_left;
        pend_new[RES_REDGE] = has_up && row_end;
        pend_new[RES_BOT]   = last_row && has_left;
        pend_new[RES_CORN]  = last_row && row_end;

        if (row_end) begin
            col_next = '0;
            row_next = last_row ? '0 : row_count_reg + ROW_W'(1);
        end else begin
            col_next = col_count_reg + COL_W'(1);
            row_next = row_count_reg;
        end
    end

    // prefetch the column the next item will use
    assign rd_addr = in_acc ? col_next : col_count_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            line_mem[col_count_reg] <= {ls[0], mask_bit};
        end
        ls_rd_reg <= line_mem[rd_addr];
    end

    always_comb begin
        pend_next = pend_reg;
        if (in_acc)       pend_next = pend_new;
        else if (out_acc) pend_next = pend_rest;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            window_reg    <= '0;
            pend_reg      <= '0;
        end else begin
            pend_reg <= pend_next;
            if (in_acc) begin
                col_count_reg <= col_next;
                row_count_reg <= row_next;
                window_reg    <= window_next;
            end
        end
    end

    // payload of the buffered item, no reset needed
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_row_reg <= row_count_reg;
            res_col_reg <= col_count_reg;
            res_win_reg <= window_next;
        end
    end

    // emit pending results lowest slot first
    always_comb begin
        if (pend_reg[RES_INNER]) begin
            sel_row  = res_row_reg - ROW_W'(1);
            sel_col  = res_col_reg - COL_W'(1);
            sel_mask = WIN_ALL;
            sel_fend = 1'b0;
        end else if (pend_reg[RES_REDGE]) begin
            sel_row  = res_row_reg - ROW_W'(1);
            sel_col  = res_col_reg;
            sel_mask = WIN_RIGHT_CLIP;
            sel_fend = 1'b0;
        end else if (pend_reg[RES_BOT]) begin
            sel_row  = res_row_reg;
            sel_col  = res_col_reg - COL_W'(1);
            sel_mask = WIN_BOTTOM_CLIP;
            sel_fend = 1'b0;
        end else begin
            sel_row  = res_row_reg;
            sel_col  = res_col_reg;
            sel_mask = WIN_CORNER_CLIP;
            sel_fend = 1'b1;
        end
    end

    assign m_tvalid = pend_reg != '0;
    assign m_tdata  = {3'b000, |(res_win_reg & sel_mask), sel_col, sel_row};
    assign m_tlast  = pend_rest == '0;
    assign m_tuser  = sel_fend;

    `ASSERT_IMPL(a_fend_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast,
                 "frame end result is not the last result of its item")
    `ASSERT_IMPL(a_ready_drained, aclk, aresetn, s_tready, $countones(pend_reg) <= 1,
                 "input ready while more than one result is pending")
    `ASSERT_NEXT(a_row_wrap, aclk, aresetn, in_acc && row_end, col_count_reg == '0,
                 "column counter did not wrap at row end")

endmodule

`default_nettype wire
